[design/irqsc_pkg.sv]
// Shared types and constants for the interrupt statistics and credit monitor.
// Holds the per-source record layout, operation codes and the cleared record.
// No dependencies.
`default_nettype none

package irqsc_pkg;

  // Operation codes carried with each request
  typedef enum logic [2:0] {
    OP_ENTER      = 3'd0,
    OP_LEAVE      = 3'd1,
    OP_SET_CREDIT = 3'd2,
    OP_CONSUME    = 3'd3,
    OP_CLEAR      = 3'd4
  } op_e;

  localparam logic [30:0] MAX31        = 31'h7FFF_FFFF;
  localparam logic [30:0] WARMUP_COUNT = 31'd5;
  localparam logic [31:0] CREDIT_OFF   = 32'hFFFF_FFFF;

  // Per-source record as kept in the state memory
  typedef struct packed {
    logic [31:0]        entry_time;
    logic [31:0]        prev_entry_time;
    logic [30:0]        period_min;
    logic [30:0]        period_max;
    logic [30:0]        duration_min;
    logic [30:0]        duration_max;
    logic [30:0]        leave_count;
    logic signed [31:0] credit;
  } rec_t;

  // Record as seen after reset
  function automatic rec_t reset_rec();
    rec_t r;
    r.entry_time      = '0;
    r.prev_entry_time = '0;
    r.period_min      = MAX31;
    r.period_max      = '0;
    r.duration_min    = MAX31;
    r.duration_max    = '0;
    r.leave_count     = '0;
    r.credit          = CREDIT_OFF;
    return r;
  endfunction

endpackage

`default_nettype wire

[design/irq_stats_and_credit_monitor.sv]
// Per-source interrupt statistics and credit monitor.
//
// Request channel: operation, source, timestamp and credit value, taken at a
// rising edge with in_valid_i high and in_stall_o low. Result channel: the
// addressed source's record after the update, offered with out_valid_o and
// taken when out_stall_i is low. Exactly one result per request, in order.
//
// A request moves from the update stage to the result register when that
// register is empty or being taken. Throughput: one request per cycle while
// the receiver does not stall. Each request makes one read-modify-write of
// the record memory: read on acceptance, update and write-back as it leaves
// the update stage; a back-to-back request to the same source takes the
// just-written record from a forwarding register.
//
// Reset clears the pipeline and the per-source valid bits; a source whose
// bit is clear reads as the cleared record, so no clearing pass is needed.
// Sources at or above SOURCES return a cleared record and change nothing.
// While the receiver stalls, the result holds; one more request may sit in
// the update stage, after which in_stall_o is raised.
`default_nettype none

module irq_stats_and_credit_monitor #(
  parameter int SOURCES = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [2:0]         operation_i,
  input  wire logic [2:0]         source_i,
  input  wire logic [31:0]        timestamp_i,
  input  wire logic signed [31:0] credit_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [30:0]             period_lo_o,
  output logic [30:0]             period_hi_o,
  output logic [30:0]             duration_lo_o,
  output logic [30:0]             duration_hi_o,
  output logic [30:0]             event_count_o,
  output logic signed [31:0]      credit_left_o,
  output logic                    disable_now_o
);

  localparam int ADDR_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int REC_W  = $bits(irqsc_pkg::rec_t);

  logic                  accept;
  logic                  s1_move;
  logic                  wr_en;
  logic [ADDR_W-1:0]     in_addr;
  logic                  in_range;

  logic                  s1_valid_q, s1_valid_d;
  irqsc_pkg::op_e        s1_op_q;
  logic [ADDR_W-1:0]     s1_addr_q;
  logic                  s1_inr_q;
  logic [31:0]           s1_ts_q;
  logic [31:0]           s1_cv_q;
  logic                  fwd_q;
  logic                  rvalid_q;
  irqsc_pkg::rec_t       wrec_q;
  logic [SOURCES-1:0]    valid_q;

  logic [REC_W-1:0]      rdata;
  irqsc_pkg::rec_t       base_rec;
  irqsc_pkg::rec_t       new_rec;
  irqsc_pkg::rec_t       res_rec;
  logic                  upd_disable;

  logic                  out_valid_q, out_valid_d;
  irqsc_pkg::rec_t       out_rec_q;
  logic                  out_dis_q;

  // Handshake and address decode
  assign in_addr    = ADDR_W'(source_i);
  assign in_range   = ({29'd0, source_i} < 32'(SOURCES));
  assign s1_move    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_move;
  assign accept     = in_valid_i && !in_stall_o;
  assign wr_en      = s1_valid_q && s1_move && s1_inr_q;

  // Record store
  irqsc_ram #(
    .WIDTH (REC_W),
    .DEPTH (SOURCES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (new_rec),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  // Pick forwarded, stored or cleared record
  always_comb begin
    if (fwd_q) begin
      base_rec = wrec_q;
    end else if (rvalid_q) begin
      base_rec = irqsc_pkg::rec_t'(rdata);
    end else begin
      base_rec = irqsc_pkg::reset_rec();
    end
  end

  irqsc_update u_update (
    .op_i           (s1_op_q),
    .timestamp_i    (s1_ts_q),
    .credit_value_i (s1_cv_q),
    .rec_i          (base_rec),
    .rec_o          (new_rec),
    .disable_o      (upd_disable)
  );

  assign res_rec = s1_inr_q ? new_rec : irqsc_pkg::reset_rec();

  // Next state of the control flops
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = s1_valid_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_q       <= 1'b0;
      rvalid_q    <= 1'b0;
      valid_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        fwd_q    <= wr_en && (s1_addr_q == in_addr);
        rvalid_q <= valid_q[in_addr];
      end
      if (wr_en) begin
        valid_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  // Capture the request and the written-back record
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= irqsc_pkg::op_e'(operation_i);
      s1_addr_q <= in_addr;
      s1_inr_q  <= in_range;
      s1_ts_q   <= timestamp_i;
      s1_cv_q   <= credit_value_i;
    end
    if (wr_en) begin
      wrec_q <= new_rec;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      out_rec_q <= res_rec;
      out_dis_q <= s1_inr_q && upd_disable;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign period_lo_o    = out_rec_q.period_min;
  assign period_hi_o    = out_rec_q.period_max;
  assign duration_lo_o  = out_rec_q.duration_min;
  assign duration_hi_o  = out_rec_q.duration_max;
  assign event_count_o  = out_rec_q.leave_count;
  assign credit_left_o  = out_rec_q.credit;
  assign disable_now_o  = out_dis_q;

endmodule

`default_nettype wire

[design/irqsc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the per-source record store.
`default_nettype none

module irqsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/irqsc_update.sv]
// Record update for one request: period/duration statistics and credit.
// Depends on irqsc_pkg for the record type and operation codes.
`default_nettype none

module irqsc_update (
  input  wire irqsc_pkg::op_e  op_i,
  input  wire logic [31:0]     timestamp_i,
  input  wire logic [31:0]     credit_value_i,
  input  wire irqsc_pkg::rec_t rec_i,
  output irqsc_pkg::rec_t      rec_o,
  output logic                 disable_o
);

  logic [31:0] period;
  logic [31:0] duration;
  logic [30:0] count_next;

  // Wrapping differences against the stored entry times
  assign period   = rec_i.entry_time - rec_i.prev_entry_time;
  assign duration = timestamp_i - rec_i.entry_time;
  assign count_next = (rec_i.leave_count != irqsc_pkg::MAX31) ?
                      rec_i.leave_count + 31'd1 : rec_i.leave_count;

  // Apply the operation
  always_comb begin
    rec_o     = rec_i;
    disable_o = 1'b0;
    case (op_i)
      irqsc_pkg::OP_ENTER: begin
        rec_o.prev_entry_time = rec_i.entry_time;
        rec_o.entry_time      = timestamp_i;
      end
      irqsc_pkg::OP_LEAVE: begin
        if (!period[31]) begin
          if (period[30:0] < rec_i.period_min) rec_o.period_min = period[30:0];
          if (period[30:0] > rec_i.period_max) rec_o.period_max = period[30:0];
        end
        rec_o.leave_count = count_next;
        if (!duration[31]) begin
          if (duration[30:0] < rec_i.duration_min) begin
            rec_o.duration_min = duration[30:0];
          end
          if ((count_next > irqsc_pkg::WARMUP_COUNT) &&
              (duration[30:0] > rec_i.duration_max)) begin
            rec_o.duration_max = duration[30:0];
          end
        end
      end
      irqsc_pkg::OP_SET_CREDIT: begin
        rec_o.credit = credit_value_i;
      end
      irqsc_pkg::OP_CONSUME: begin
        if (!rec_i.credit[31] && (rec_i.credit != 32'sd0)) begin
          rec_o.credit = rec_i.credit - 32'sd1;
          disable_o    = (rec_i.credit == 32'sd1);
        end
      end
      irqsc_pkg::OP_CLEAR: begin
        rec_o              = irqsc_pkg::reset_rec();
        rec_o.entry_time      = rec_i.entry_time;
        rec_o.prev_entry_time = rec_i.prev_entry_time;
      end
      default: begin
        rec_o = rec_i;
      end
    endcase
  end

endmodule

`default_nettype wire

[sim/irq_stats_checker.sv]
// Checker for the interrupt statistics and credit monitor.
// Watches the request and result channels, keeps its own copy of the source
// records and compares every result. Depends on irqsc_pkg.
module irq_stats_checker #(
  parameter int NUM_SOURCES = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  input  wire logic               req_stall_i,
  input  wire logic [2:0]         req_op_i,
  input  wire logic [2:0]         req_src_i,
  input  wire logic [31:0]        req_ts_i,
  input  wire logic signed [31:0] req_credit_i,
  input  wire logic               rsp_valid_i,
  input  wire logic               rsp_stall_i,
  input  wire logic [30:0]        rsp_period_lo_i,
  input  wire logic [30:0]        rsp_period_hi_i,
  input  wire logic [30:0]        rsp_duration_lo_i,
  input  wire logic [30:0]        rsp_duration_hi_i,
  input  wire logic [30:0]        rsp_event_count_i,
  input  wire logic signed [31:0] rsp_credit_left_i,
  input  wire logic               rsp_disable_now_i,
  output int unsigned             errors_o,
  output int unsigned             outstanding_o
);

  // Statistics kept per source
  typedef struct {
    logic [31:0]        entered;
    logic [31:0]        entered_prev;
    logic [30:0]        per_lo;
    logic [30:0]        per_hi;
    logic [30:0]        dur_lo;
    logic [30:0]        dur_hi;
    logic [30:0]        leaves;
    logic signed [31:0] credit;
  } src_stats_t;

  // Record returned for one request
  typedef struct packed {
    logic [30:0]        period_lo;
    logic [30:0]        period_hi;
    logic [30:0]        duration_lo;
    logic [30:0]        duration_hi;
    logic [30:0]        event_count;
    logic signed [31:0] credit_left;
    logic               disable_now;
  } irq_report_t;

  src_stats_t  stats [NUM_SOURCES];
  irq_report_t pending_reports [$];
  irq_report_t want;
  int unsigned errors = 0;

  // Drop statistics and credit, keep the entry times
  function automatic src_stats_t wipe_stats(input src_stats_t s);
    src_stats_t w;
    w        = s;
    w.per_lo = irqsc_pkg::MAX31;
    w.per_hi = '0;
    w.dur_lo = irqsc_pkg::MAX31;
    w.dur_hi = '0;
    w.leaves = '0;
    w.credit = irqsc_pkg::CREDIT_OFF;
    return w;
  endfunction

  // Apply one request to the source records and return the record it yields
  function automatic irq_report_t account_request(input logic [2:0] op, input logic [2:0] src,
                                                  input logic [31:0] ts,
                                                  input logic signed [31:0] cv);
    src_stats_t  s;
    logic [31:0] period;
    logic [31:0] span;
    irq_report_t rep;
    rep = '{period_lo: irqsc_pkg::MAX31, period_hi: '0, duration_lo: irqsc_pkg::MAX31,
            duration_hi: '0, event_count: '0, credit_left: irqsc_pkg::CREDIT_OFF,
            disable_now: 1'b0};
    if (src >= NUM_SOURCES) return rep;
    s = stats[src];
    case (op)
      irqsc_pkg::OP_ENTER: begin
        s.entered_prev = s.entered;
        s.entered      = ts;
      end
      irqsc_pkg::OP_LEAVE: begin
        period = s.entered - s.entered_prev;
        span   = ts - s.entered;
        // negative differences leave the period and duration statistics alone
        if (!period[31]) begin
          if (period[30:0] < s.per_lo) s.per_lo = period[30:0];
          if (period[30:0] > s.per_hi) s.per_hi = period[30:0];
        end
        if (s.leaves != irqsc_pkg::MAX31) s.leaves = s.leaves + 1'b1;
        if (!span[31]) begin
          if (span[30:0] < s.dur_lo) s.dur_lo = span[30:0];
          if (s.leaves > irqsc_pkg::WARMUP_COUNT && span[30:0] > s.dur_hi) begin
            s.dur_hi = span[30:0];
          end
        end
      end
      irqsc_pkg::OP_SET_CREDIT: s.credit = cv;
      irqsc_pkg::OP_CONSUME: begin
        if (s.credit > 0) begin
          s.credit        = s.credit - 1;
          rep.disable_now = (s.credit == 0);
        end
      end
      irqsc_pkg::OP_CLEAR: s = wipe_stats(s);
      default: ;
    endcase
    stats[src]      = s;
    rep.period_lo   = s.per_lo;
    rep.period_hi   = s.per_hi;
    rep.duration_lo = s.dur_lo;
    rep.duration_hi = s.dur_hi;
    rep.event_count = s.leaves;
    rep.credit_left = s.credit;
    return rep;
  endfunction

  task automatic check_field(input string label, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, exp_val, got_val);
      errors++;
    end
  endtask

  // Compare the result on the channel against the oldest expected record
  task automatic compare_report(input irq_report_t exp_rep);
    check_field("period_lo", 32'(exp_rep.period_lo), 32'(rsp_period_lo_i));
    check_field("period_hi", 32'(exp_rep.period_hi), 32'(rsp_period_hi_i));
    check_field("duration_lo", 32'(exp_rep.duration_lo), 32'(rsp_duration_lo_i));
    check_field("duration_hi", 32'(exp_rep.duration_hi), 32'(rsp_duration_hi_i));
    check_field("event_count", 32'(exp_rep.event_count), 32'(rsp_event_count_i));
    check_field("credit_left", exp_rep.credit_left, rsp_credit_left_i);
    check_field("disable_now", 32'(exp_rep.disable_now), 32'(rsp_disable_now_i));
  endtask

  // Retire results first, then account for the request taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        stats[i].entered      = '0;
        stats[i].entered_prev = '0;
        stats[i]              = wipe_stats(stats[i]);
      end
      pending_reports.delete();
      outstanding_o <= 0;
    end else begin
      if (rsp_valid_i && !rsp_stall_i) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, got event_count %0h", $time,
                   rsp_event_count_i);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          compare_report(want);
        end
      end
      if (req_valid_i && !req_stall_i) begin
        pending_reports.push_back(account_request(req_op_i, req_src_i, req_ts_i, req_credit_i));
      end
      outstanding_o <= pending_reports.size();
    end
    errors_o <= errors;
  end

endmodule

[sim/irq_stats_and_credit_monitor_tb.sv]
// Testbench top for the interrupt statistics and credit monitor.
// Drives corner-case and random requests under varying idle and stall
// patterns; depends on irqsc_pkg, the block and irq_stats_checker.
module irq_stats_and_credit_monitor_tb;

  localparam int CLK_PERIOD     = 8;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int HOLD_CYCLES    = 60;
  localparam int PHASE_REQUESTS = 430;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         operation_i;
  logic [2:0]         source_i;
  logic [31:0]        timestamp_i;
  logic signed [31:0] credit_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [30:0]        period_lo_o;
  logic [30:0]        period_hi_o;
  logic [30:0]        duration_lo_o;
  logic [30:0]        duration_hi_o;
  logic [30:0]        event_count_o;
  logic signed [31:0] credit_left_o;
  logic               disable_now_o;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned requests      = 0;
  logic [31:0] tick          = '0;
  logic        hold_req      = 1'b0;
  logic        hold_seen     = 1'b0;
  int unsigned hold_left     = 0;

  irq_stats_and_credit_monitor #(.SOURCES(8)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .source_i       (source_i),
    .timestamp_i    (timestamp_i),
    .credit_value_i (credit_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .period_lo_o    (period_lo_o),
    .period_hi_o    (period_hi_o),
    .duration_lo_o  (duration_lo_o),
    .duration_hi_o  (duration_hi_o),
    .event_count_o  (event_count_o),
    .credit_left_o  (credit_left_o),
    .disable_now_o  (disable_now_o)
  );

  irq_stats_checker #(.NUM_SOURCES(8)) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_valid_i        (in_valid_i),
    .req_stall_i        (in_stall_o),
    .req_op_i           (operation_i),
    .req_src_i          (source_i),
    .req_ts_i           (timestamp_i),
    .req_credit_i       (credit_value_i),
    .rsp_valid_i        (out_valid_o),
    .rsp_stall_i        (out_stall_i),
    .rsp_period_lo_i    (period_lo_o),
    .rsp_period_hi_i    (period_hi_o),
    .rsp_duration_lo_i  (duration_lo_o),
    .rsp_duration_hi_i  (duration_hi_o),
    .rsp_event_count_i  (event_count_o),
    .rsp_credit_left_i  (credit_left_o),
    .rsp_disable_now_i  (disable_now_o),
    .errors_o           (errors),
    .outstanding_o      (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one request, idling first at random, and hold it until taken
  task automatic send_request(input logic [2:0] op, input logic [2:0] src,
                              input logic [31:0] ts, input logic signed [31:0] cv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    operation_i    <= op;
    source_i       <= src;
    timestamp_i    <= ts;
    credit_value_i <= cv;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    requests++;
  endtask

  // Stop offering and wait until every result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Corner cases: credit edges, wrapping and negative differences, unused codes
  task automatic corner_requests();
    send_request(irqsc_pkg::OP_CONSUME, 3'd0, '0, '0);
    send_request(irqsc_pkg::OP_SET_CREDIT, 3'd0, '0, 32'sd2);
    repeat (3) send_request(irqsc_pkg::OP_CONSUME, 3'd0, '0, '0);
    send_request(irqsc_pkg::OP_SET_CREDIT, 3'd1, '0, 32'sh7FFF_FFFF);
    send_request(irqsc_pkg::OP_CONSUME, 3'd1, 32'hFFFF_FFFF, '0);
    send_request(irqsc_pkg::OP_SET_CREDIT, 3'd1, '0, 32'sh8000_0000);
    send_request(irqsc_pkg::OP_CONSUME, 3'd1, '0, '0);
    send_request(irqsc_pkg::OP_ENTER, 3'd2, 32'hFFFF_FFF0, '0);
    send_request(irqsc_pkg::OP_LEAVE, 3'd2, 32'h0000_0010, '0);
    send_request(irqsc_pkg::OP_ENTER, 3'd2, 32'h0000_0010, '0);
    send_request(irqsc_pkg::OP_LEAVE, 3'd2, 32'h0000_0010, '0);
    send_request(irqsc_pkg::OP_ENTER, 3'd3, 32'h8000_0000, '0);
    send_request(irqsc_pkg::OP_LEAVE, 3'd3, 32'h0000_0000, 32'shFFFF_FFFF);
    send_request(irqsc_pkg::OP_ENTER, 3'd6, 32'h7FFF_FFFF, '0);
    send_request(irqsc_pkg::OP_LEAVE, 3'd6, 32'hFFFF_FFFE, '0);
    // a source never entered, left often enough to pass the warm-up
    for (int k = 1; k <= 6; k++) send_request(irqsc_pkg::OP_LEAVE, 3'd4, 32'(k * 100), '0);
    send_request(3'(irqsc_pkg::OP_CLEAR) + 3'd1, 3'd7, '0, '0);
    send_request(3'(irqsc_pkg::OP_CLEAR) + 3'd2, 3'd7, '0, '0);
    send_request(3'(irqsc_pkg::OP_CLEAR) + 3'd3, 3'd7, '0, '0);
    send_request(irqsc_pkg::OP_CLEAR, 3'd2, '0, '0);
  endtask

  // Mostly ordered enter/leave traffic with credit work, some noise
  task automatic random_request();
    int unsigned        pick;
    logic [2:0]         op;
    logic [2:0]         src;
    logic [31:0]        ts;
    logic signed [31:0] cv;
    pick = $urandom_range(99);
    src  = 3'($urandom_range(7));
    tick = tick + $urandom_range(1, 40);
    ts   = tick;
    cv   = 32'($urandom);
    if (pick < 32) begin
      op = irqsc_pkg::OP_ENTER;
    end else if (pick < 64) begin
      op = irqsc_pkg::OP_LEAVE;
    end else if (pick < 72) begin
      op = irqsc_pkg::OP_CONSUME;
    end else if (pick < 80) begin
      op = irqsc_pkg::OP_SET_CREDIT;
      case ($urandom_range(3))
        0: cv = 32'($urandom_range(1, 4));
        1: cv = irqsc_pkg::CREDIT_OFF;
        2: cv = '0;
        default: ;
      endcase
    end else if (pick < 83) begin
      op = irqsc_pkg::OP_CLEAR;
    end else if (pick < 86) begin
      op = 3'($urandom_range(7, 32'(irqsc_pkg::OP_CLEAR) + 1));
    end else begin
      op = 3'($urandom);
      ts = 32'($urandom);
    end
    send_request(op, src, ts, cv);
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = irqsc_pkg::OP_ENTER;
    source_i       = '0;
    timestamp_i    = '0;
    credit_value_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    corner_requests();
    drain_results();

    // sender rarely idle, receiver often stalled; long hold-off fills the block
    send_idle_pct = 7;
    recv_idle_pct <= 57;
    hold_req      <= ~hold_req;
    repeat (PHASE_REQUESTS) random_request();
    drain_results();

    // sender often idle, receiver rarely stalled; time wraps early on
    send_idle_pct = 57;
    recv_idle_pct <= 7;
    tick = 32'hFFFF_F000;
    repeat (PHASE_REQUESTS) random_request();
    drain_results();

    // full rate both ways, with one more hold-off
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req      <= ~hold_req;
    repeat (PHASE_REQUESTS) random_request();
    drain_results();
    repeat (4) @(posedge clk_i);

    $display("Ran %0d requests: corner cases, three idle/stall mixes, two long result",
             requests);
    $display("hold-offs and drain pauses between phases.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TB_ERROR");
    $finish;
  end

endmodule
